// ----- rtl/core/mcpf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcpf_pkg
// Shared types, constants and the sequencer microcode for the motor command
// packet framer.
// ----------------------------------------------------------------------------
package mcpf_pkg;

  localparam int ROBOTS   = 3;
  localparam int RobotW   = (ROBOTS > 1) ? $clog2(ROBOTS) : 1;
  localparam int StepW    = 4;
  localparam int FrameLen = 4 + 4 * ROBOTS + 2;

  typedef enum logic [1:0] {
    MODE_SET  = 2'd0,
    MODE_SEND = 2'd1,
    MODE_STOP = 2'd2
  } mode_e;

  typedef enum logic [0:0] {
    CFG_HEADER_FIRST  = 1'b0,
    CFG_HEADER_SECOND = 1'b1
  } cfg_idx_e;

  localparam logic [7:0] DriveMax  = 8'hFF;
  localparam logic [7:0] ByteZero  = 8'h00;
  localparam logic [1:0] FlagLeft  = 2'b01;
  localparam logic [1:0] FlagRight = 2'b10;

  typedef struct packed {
    logic [1:0]         mode;
    logic [7:0]         robot_index;
    logic signed [15:0] drive_left;
    logic signed [15:0] drive_right;
    logic               reverse_left;
    logic               reverse_right;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } out_item_t;

  typedef struct packed {
    logic [7:0] left;
    logic [7:0] right;
    logic [1:0] flags;
  } cmd_entry_t;

  // Frame header values handed to the sequencer.
  typedef struct packed {
    logic [7:0]  header_first;
    logic [7:0]  header_second;
    logic [15:0] frame_count;
  } frame_hdr_t;

  typedef enum logic [2:0] {
    SRC_HDR1,
    SRC_HDR2,
    SRC_CNT_LO,
    SRC_CNT_HI,
    SRC_ID,
    SRC_LEFT,
    SRC_RIGHT,
    SRC_FLAGS
  } byte_src_e;

  // One microcode word: byte source, zero override, checksum select,
  // loop-back over robots, and end of program.
  typedef struct packed {
    byte_src_e        src;
    logic             zero;
    logic             sum;
    logic             loop;
    logic [StepW-1:0] target;
    logic             last;
  } ucode_t;

  localparam logic [StepW-1:0] StepRobot = StepW'(4);

  function automatic ucode_t ucode_rom(input logic [StepW-1:0] step);
    ucode_t w;
    w = '{src: SRC_HDR1, zero: 1'b0, sum: 1'b0, loop: 1'b0,
          target: StepRobot, last: 1'b0};
    case (step)
      StepW'(0): w.src = SRC_HDR1;
      StepW'(1): w.src = SRC_HDR2;
      StepW'(2): w.src = SRC_CNT_LO;
      StepW'(3): w.src = SRC_CNT_HI;
      StepW'(4): w.src = SRC_ID;
      StepW'(5): w.src = SRC_LEFT;
      StepW'(6): w.src = SRC_RIGHT;
      StepW'(7): begin
        w.src  = SRC_FLAGS;
        w.loop = 1'b1;
      end
      StepW'(8): w.zero = 1'b1;
      StepW'(9): begin
        w.sum  = 1'b1;
        w.last = 1'b1;
      end
      default: begin
        w.sum  = 1'b1;
        w.last = 1'b1;
      end
    endcase
    return w;
  endfunction

  // Clamp a signed drive request to 0..255.
  function automatic logic [7:0] saturate_drive(input logic signed [15:0] raw);
    logic [7:0] res;
    if (raw[15]) begin
      res = ByteZero;
    end else if (|raw[14:8]) begin
      res = DriveMax;
    end else begin
      res = raw[7:0];
    end
    return res;
  endfunction

endpackage

// ----- rtl/core/mcpf_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcpf_seq
// Microcoded frame sequencer: steps through the ROM program, one byte per
// step, with a robot loop counter, running XOR checksum and output register.
// ----------------------------------------------------------------------------
module mcpf_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  mcpf_pkg::frame_hdr_t          hdr_i,
  input  mcpf_pkg::cmd_entry_t          entry_i,
  output logic [mcpf_pkg::RobotW-1:0]   robot_o,
  output logic                          busy_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output mcpf_pkg::out_item_t           out_o
);
  import mcpf_pkg::*;

  logic             run_q, run_d;
  logic [StepW-1:0] step_q, step_d;
  logic [RobotW-1:0] robot_q, robot_d;
  logic [7:0]       sum_q, sum_d;
  logic             oval_q, oval_d;
  out_item_t        out_q, out_d;
  ucode_t           uw;
  logic             fire;
  logic             more;
  logic [7:0]       src_byte;
  logic [7:0]       byte_val;

  assign uw   = ucode_rom(step_q);
  assign fire = run_q && (!oval_q || out_ready_i);
  assign more = (robot_q != RobotW'(ROBOTS - 1));

  always_comb begin
    case (uw.src)
      SRC_HDR1:   src_byte = hdr_i.header_first;
      SRC_HDR2:   src_byte = hdr_i.header_second;
      SRC_CNT_LO: src_byte = hdr_i.frame_count[7:0];
      SRC_CNT_HI: src_byte = hdr_i.frame_count[15:8];
      SRC_ID:     src_byte = 8'(robot_q);
      SRC_LEFT:   src_byte = entry_i.left;
      SRC_RIGHT:  src_byte = entry_i.right;
      SRC_FLAGS:  src_byte = {6'b0, entry_i.flags};
      default:    src_byte = ByteZero;
    endcase
    if (uw.sum) begin
      byte_val = sum_q;
    end else if (uw.zero) begin
      byte_val = ByteZero;
    end else begin
      byte_val = src_byte;
    end
  end

  always_comb begin
    run_d   = run_q;
    step_d  = step_q;
    robot_d = robot_q;
    sum_d   = sum_q;
    oval_d  = oval_q;
    out_d   = out_q;
    if (out_ready_i) begin
      oval_d = 1'b0;
    end
    if (start_i) begin
      run_d   = 1'b1;
      step_d  = '0;
      robot_d = '0;
      sum_d   = ByteZero;
    end else if (fire) begin
      oval_d           = 1'b1;
      out_d.frame_byte = byte_val;
      out_d.frame_end  = uw.last;
      sum_d            = sum_q ^ byte_val;
      if (uw.last) begin
        run_d = 1'b0;
      end else if (uw.loop && more) begin
        step_d  = uw.target;
        robot_d = robot_q + RobotW'(1);
      end else begin
        step_d = step_q + StepW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      step_q  <= '0;
      robot_q <= '0;
      oval_q  <= 1'b0;
    end else begin
      run_q   <= run_d;
      step_q  <= step_d;
      robot_q <= robot_d;
      oval_q  <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    out_q <= out_d;
  end

  assign robot_o     = robot_q;
  assign busy_o      = run_q;
  assign out_valid_o = oval_q;
  assign out_o       = out_q;

endmodule

// ----- rtl/core/motor_command_packet_framer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_command_packet_framer_core
// Robot command table with a microcoded serializer for framed command packets.
// ----------------------------------------------------------------------------
// Set and stop transactions produce nothing on the output. A send
// transaction bumps the 16-bit frame counter and then streams
// 4 + 4*ROBOTS + 2 bytes (18 for three robots), one per cycle while the sink
// keeps ready high; the byte rate is set by the sequencer, which steps one
// microcode word per emitted byte through a single output register. The input
// stays stalled while a frame is being sequenced and opens again as soon as
// the checksum byte is loaded into the output register, so any sink stall
// keeps the input stalled longer. No clearing pass: the command table is in
// flops and reset clears it at once.
// ----------------------------------------------------------------------------
module motor_command_packet_framer_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [0:0]           cfg_idx_i,
  input  logic [7:0]           cfg_data_i,
  // command transactions
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  mcpf_pkg::in_item_t   in_i,
  // frame byte transactions
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output mcpf_pkg::out_item_t  out_o
);
  import mcpf_pkg::*;

  logic [7:0]        hdr_first_q;
  logic [7:0]        hdr_second_q;
  logic [15:0]       count_q;
  cmd_entry_t        table_q [ROBOTS];
  logic              in_acc;
  logic              do_set;
  logic              do_send;
  logic              do_stop;
  logic              busy;
  logic [RobotW-1:0] robot_rd;
  cmd_entry_t        new_entry;
  frame_hdr_t        hdr;

  // Sequential: one transaction is worked on at a time.
  assign in_ready_o = !busy;
  assign in_acc     = in_valid_i && in_ready_o;

  // Decode the mode; mode 3 falls through all three and does nothing.
  assign do_set  = in_acc && (in_i.mode == MODE_SET) &&
                   (in_i.robot_index < 8'(ROBOTS));
  assign do_send = in_acc && (in_i.mode == MODE_SEND);
  assign do_stop = in_acc && (in_i.mode == MODE_STOP);

  always_comb begin
    new_entry.left  = saturate_drive(in_i.drive_left);
    new_entry.right = saturate_drive(in_i.drive_right);
    new_entry.flags = (in_i.reverse_left  ? FlagLeft  : 2'b00) |
                      (in_i.reverse_right ? FlagRight : 2'b00);
  end

  // Header registers must only be written while idle; the block itself does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_first_q  <= ByteZero;
      hdr_second_q <= ByteZero;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HEADER_FIRST:  hdr_first_q  <= cfg_data_i;
        CFG_HEADER_SECOND: hdr_second_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Counter is bumped on accept, so the frame already carries the new value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (do_send) begin
      count_q <= count_q + 16'd1;
    end
  end

  // Command table: stop wipes every entry at once, set writes one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ROBOTS; i++) begin
        table_q[i] <= '0;
      end
    end else if (do_stop) begin
      for (int i = 0; i < ROBOTS; i++) begin
        table_q[i] <= '0;
      end
    end else if (do_set) begin
      table_q[in_i.robot_index[RobotW-1:0]] <= new_entry;
    end
  end

  assign hdr.header_first  = hdr_first_q;
  assign hdr.header_second = hdr_second_q;
  assign hdr.frame_count   = count_q;

  mcpf_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (do_send),
    .hdr_i       (hdr),
    .entry_i     (table_q[robot_rd]),
    .robot_o     (robot_rd),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

// ----- tb/motor_command_packet_framer_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_command_packet_framer_core_tb
// Self-checking bench for the motor command packet framer. Set, stop, send
// and unused-mode transactions go in, and every frame byte that comes out is
// compared against a behavioral copy of the robot table, the frame counter and
// the header registers. Directed cases come first: drive clamping, index range,
// stop, unused mode and header extremes. Random traffic follows with random
// idle gaps on both sides, a long sink hold-off, and a full-rate frame burst.
// ----------------------------------------------------------------------------
module motor_command_packet_framer_core_tb;
  import mcpf_pkg::*;

  // Mode 3 has no enum member; the block must drop it silently.
  localparam logic [1:0] ModeUnused = 2'd3;
  // Cycles without any accepted transaction before the run is declared hung.
  // The longest legal quiet stretch is the sink hold-off below.
  localparam int IdleLimit  = 4000;
  localparam int SinkHoldLen = 400;

  logic       clk;
  logic       rst_ni;
  logic       cfg_we;
  cfg_idx_e   cfg_idx;
  logic [7:0] cfg_data;
  logic       in_valid;
  logic       in_ready_o;
  in_item_t   in_item;
  logic       out_valid_o;
  logic       out_ready;
  out_item_t  out_o;

  motor_command_packet_framer_core DUT (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_i        (in_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_o       (out_o)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Behavioral copy of the block: robot table, frame counter, header bytes,
  // and the bytes that are still owed on the output.
  // --------------------------------------------------------------------------
  cmd_entry_t robot_cmds [ROBOTS];
  logic [15:0] frames_sent;
  logic [7:0]  hdr_first;
  logic [7:0]  hdr_second;
  out_item_t   expected_bytes_q [$];

  int  mismatch_count;
  int  idle_cycles;
  bit  source_stalls;
  bit  sink_stalls;
  int  sink_hold_req;

  // Clamp a signed drive request into the 0..255 byte range.
  function automatic logic [7:0] limit_drive(input logic signed [15:0] req);
    if (req < 0) return ByteZero;
    if (req > 255) return DriveMax;
    return req[7:0];
  endfunction

  // Update the table copy for one accepted transaction; a send also queues
  // the whole frame it must produce.
  function automatic void apply_command(input in_item_t item);
    logic [7:0] frame_bytes [FrameLen];
    logic [7:0] chk;
    case (item.mode)
      MODE_SET: begin
        if (item.robot_index < ROBOTS) begin
          robot_cmds[item.robot_index].left  = limit_drive(item.drive_left);
          robot_cmds[item.robot_index].right = limit_drive(item.drive_right);
          robot_cmds[item.robot_index].flags = (item.reverse_left  ? FlagLeft  : 2'b00) |
                                               (item.reverse_right ? FlagRight : 2'b00);
        end
      end
      MODE_STOP: begin
        for (int i = 0; i < ROBOTS; i++) robot_cmds[i] = '0;
      end
      MODE_SEND: begin
        // counter bumps before it goes into the frame
        frames_sent    = frames_sent + 16'd1;
        frame_bytes[0] = hdr_first;
        frame_bytes[1] = hdr_second;
        frame_bytes[2] = frames_sent[7:0];
        frame_bytes[3] = frames_sent[15:8];
        for (int i = 0; i < ROBOTS; i++) begin
          frame_bytes[4 + 4 * i] = 8'(i);
          frame_bytes[5 + 4 * i] = robot_cmds[i].left;
          frame_bytes[6 + 4 * i] = robot_cmds[i].right;
          frame_bytes[7 + 4 * i] = {6'b0, robot_cmds[i].flags};
        end
        frame_bytes[FrameLen - 2] = ByteZero;
        chk = ByteZero;
        for (int i = 0; i < FrameLen - 1; i++) begin
          chk ^= frame_bytes[i];
          expected_bytes_q.push_back('{frame_byte: frame_bytes[i], frame_end: 1'b0});
        end
        expected_bytes_q.push_back('{frame_byte: chk, frame_end: 1'b1});
      end
      default: ;  // unused mode: nothing changes
    endcase
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [15:0] random_drive();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(0, 255));
      2:       return 16'($urandom_range(250, 270));
      default: return 16'(0 - $urandom_range(1, 4));
    endcase
  endfunction

  // A transaction of the given mode with every other field random, since
  // fields the mode does not use must not matter.
  function automatic in_item_t command_of(input logic [1:0] mode);
    in_item_t item;
    item.mode          = mode;
    item.robot_index   = 8'($urandom);
    item.drive_left    = 16'($urandom);
    item.drive_right   = 16'($urandom);
    item.reverse_left  = 1'($urandom);
    item.reverse_right = 1'($urandom);
    return item;
  endfunction

  function automatic in_item_t robot_command(input logic [7:0] idx,
                                             input logic signed [15:0] left,
                                             input logic signed [15:0] right,
                                             input logic rev_l, input logic rev_r);
    in_item_t item;
    item = command_of(MODE_SET);
    item.robot_index   = idx;
    item.drive_left    = left;
    item.drive_right   = right;
    item.reverse_left  = rev_l;
    item.reverse_right = rev_r;
    return item;
  endfunction

  function automatic in_item_t random_command();
    in_item_t item;
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      item = command_of(MODE_SET);
      item.drive_left  = random_drive();
      item.drive_right = random_drive();
      // mostly live entries, sometimes an index past the table
      if ($urandom_range(0, 9) == 0) item.robot_index = 8'($urandom_range(ROBOTS, 255));
      else item.robot_index = 8'($urandom_range(0, ROBOTS - 1));
    end else if (r < 80) begin
      item = command_of(MODE_SEND);
    end else if (r < 92) begin
      item = command_of(MODE_STOP);
    end else begin
      item = command_of(ModeUnused);
    end
    return item;
  endfunction

  // --------------------------------------------------------------------------
  // Source side. Called and returns at a falling edge; valid stays up after
  // the transaction so a back-to-back follow-up never toggles it.
  // --------------------------------------------------------------------------
  task automatic send_command(input in_item_t item);
    int gap;
    gap = source_stalls ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    do @(posedge clk); while (!in_ready_o);
    apply_command(item);
    @(negedge clk);
  endtask

  // Let every owed byte come out, then a few more cycles so a trailing set or
  // stop has surely landed before anything else changes.
  task automatic drain_frames(input int tail);
    in_valid <= 1'b0;
    while (expected_bytes_q.size() != 0) @(negedge clk);
    repeat (tail) @(negedge clk);
  endtask

  // Both header registers in consecutive cycles; write enable stays high
  // across the pair.
  task automatic write_headers(input logic [7:0] first, input logic [7:0] second);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_HEADER_FIRST;
    cfg_data <= first;
    @(negedge clk);
    cfg_idx  <= CFG_HEADER_SECOND;
    cfg_data <= second;
    @(negedge clk);
    cfg_we   <= 1'b0;
    hdr_first  = first;
    hdr_second = second;
  endtask

  // --------------------------------------------------------------------------
  // Sink side: random ready gaps, or a long hold-off on request.
  // --------------------------------------------------------------------------
  initial begin : sink_driver
    int gap;
    out_ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk);
      if (sink_hold_req > 0) begin
        out_ready <= 1'b0;
        repeat (sink_hold_req) @(negedge clk);
        sink_hold_req = 0;
      end else if (sink_stalls) begin
        gap = pick_gap();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      out_ready <= 1'b1;
    end
  end

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // Every accepted byte against the oldest owed byte, field by field.
  always @(posedge clk) begin
    out_item_t owed;
    if (rst_ni && out_valid_o && out_ready) begin
      if (expected_bytes_q.size() == 0) begin
        flag_mismatch($sformatf("frame byte %02h (end %0b) with no frame pending",
                                out_o.frame_byte, out_o.frame_end));
      end else begin
        owed = expected_bytes_q.pop_front();
        if (out_o.frame_byte !== owed.frame_byte)
          flag_mismatch($sformatf("frame_byte: expected %02h, got %02h",
                                  owed.frame_byte, out_o.frame_byte));
        if (out_o.frame_end !== owed.frame_end)
          flag_mismatch($sformatf("frame_end: expected %0b, got %0b",
                                  owed.frame_end, out_o.frame_end));
      end
    end
  end

  // Hang detector: any transaction on either side clears the count.
  always @(posedge clk) begin
    if (!rst_ni || (in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Out of reset: zero headers, empty table, counter goes to 1.
  task automatic test_reset_frame();
    send_command(command_of(MODE_SEND));
  endtask

  // Clamp edges, all four flag combinations, and indexes past the table.
  task automatic test_drive_saturation();
    send_command(robot_command(8'd0, -16'sd32768, 16'sd32767, 1'b1, 1'b1));
    send_command(robot_command(8'd1, 16'sd255, 16'sd256, 1'b1, 1'b0));
    send_command(robot_command(8'd2, -16'sd1, 16'sd0, 1'b0, 1'b1));
    send_command(robot_command(8'(ROBOTS), 16'sd100, 16'sd100, 1'b1, 1'b1));
    send_command(robot_command(8'd255, 16'sd7, 16'sd9, 1'b0, 1'b1));
    send_command(command_of(MODE_SEND));
    send_command(robot_command(8'd0, 16'sd0, 16'sd1, 1'b0, 1'b0));
    send_command(command_of(MODE_SEND));
  endtask

  task automatic test_stop_all();
    send_command(command_of(MODE_STOP));
    send_command(command_of(MODE_SEND));
  endtask

  // Mode 3 must leave table and counter alone.
  task automatic test_unused_mode();
    send_command(robot_command(8'd1, 16'sd42, 16'sd300, 1'b1, 1'b0));
    send_command(command_of(ModeUnused));
    send_command(command_of(MODE_SEND));
  endtask

  // Header registers at both extremes and a mixed pattern; written idle only.
  task automatic test_header_config();
    drain_frames(4);
    write_headers(8'hFF, 8'h00);
    send_command(command_of(MODE_SEND));
    drain_frames(4);
    write_headers(8'h00, 8'hFF);
    send_command(command_of(MODE_SEND));
    drain_frames(4);
    write_headers(8'hA5, 8'h5A);
    send_command(command_of(MODE_SEND));
  endtask

  // Random mix, one phase with gaps on both sides and one at full rate.
  task automatic test_random_traffic();
    drain_frames(4);
    write_headers(8'($urandom), 8'($urandom));
    source_stalls = 1'b1;
    sink_stalls   = 1'b1;
    repeat (150) send_command(random_command());
    drain_frames(4);
    write_headers(8'($urandom), 8'($urandom));
    source_stalls = 1'b0;
    sink_stalls   = 1'b0;
    repeat (150) send_command(random_command());
  endtask

  // Sink goes quiet for a long stretch while sends keep coming, so the output
  // register fills and the input must stall; then random traffic resumes.
  task automatic test_backpressure();
    drain_frames(4);
    write_headers(8'($urandom), 8'($urandom));
    source_stalls = 1'b0;
    sink_hold_req = SinkHoldLen;
    repeat (8) send_command(command_of(MODE_SEND));
    source_stalls = 1'b1;
    sink_stalls   = 1'b1;
    repeat (120) send_command(random_command());
  endtask

  // A set followed by sends back to back with the sink always ready.
  task automatic test_full_rate_frames();
    drain_frames(4);
    source_stalls = 1'b0;
    sink_stalls   = 1'b0;
    send_command(robot_command(8'd2, 16'sd200, 16'sd17, 1'b1, 1'b0));
    repeat (4) send_command(command_of(MODE_SEND));
  endtask

  initial begin
    clk           = 1'b0;
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = CFG_HEADER_FIRST;
    cfg_data      = 8'h00;
    in_valid      = 1'b0;
    in_item       = '0;
    mismatch_count = 0;
    idle_cycles   = 0;
    sink_hold_req = 0;
    source_stalls = 1'b1;
    sink_stalls   = 1'b1;
    for (int i = 0; i < ROBOTS; i++) robot_cmds[i] = '0;
    frames_sent = 16'h0000;
    hdr_first   = 8'h00;
    hdr_second  = 8'h00;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;
    @(negedge clk);

    test_reset_frame();
    test_drive_saturation();
    test_stop_all();
    test_unused_mode();
    test_header_config();
    test_random_traffic();
    test_backpressure();
    test_full_rate_frames();

    drain_frames(2 * FrameLen);
    if (expected_bytes_q.size() != 0) mismatch_count++;

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
